FILE: hdl/pjb_pkg.sv
// Shared types, constants and codes for the PCM jitter buffer.
`default_nettype none
package pjb_pkg;

   localparam int RING_DEPTH = 32768;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int SUM_W      = ((CNT_W > 16) ? CNT_W : 16) + 1;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CSR_QUEUE_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_PREBUFFER_LEVEL = 2'd1;
   localparam logic [1:0] CSR_REBUFFER_LEVEL  = 2'd2;

   localparam logic [LEVEL_W-1:0] QUEUE_LIMIT_RESET     = 16'd24576;
   localparam logic [LEVEL_W-1:0] PREBUFFER_LEVEL_RESET = 16'd9216;
   localparam logic [LEVEL_W-1:0] REBUFFER_LEVEL_RESET  = 16'd12288;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   typedef enum logic [2:0] {
      ST_STORED      = 3'd0,
      ST_DROPPED     = 3'd1,
      ST_REJECTED    = 3'd2,
      ST_REAL        = 3'd3,
      ST_UNDERRUN    = 3'd4,
      ST_HOLD        = 3'd5,
      ST_NOT_STARTED = 3'd6
   } status_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] queue_limit;
      logic [LEVEL_W-1:0] prebuffer_level;
      logic [LEVEL_W-1:0] rebuffer_level;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic               playing;
      logic               rebuffering;
      logic [LEVEL_W-1:0] pending;
      logic               is_real;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/pcm_jitter_buffer_with_rebuffer_top.sv
// A result word passes through the read stage register and then the output register before it appears.
// Throughput: one request word per clock while req_stall is low; the ring RAM has one write and one read port.
// req_stall rises only while the output register and the read stage are both held.
// Reset (synchronous, active high) clears pointers, pending count, playback state
// and the result pipeline, and restores the register defaults.
// Ring contents are not cleared; words are accepted from the first clock after reset.
`default_nettype none
module pcm_jitter_buffer_with_rebuffer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic signed [15:0]                  req_in_sample,
   input  wire logic                                req_block_start,
   input  wire logic [15:0]                         req_block_len,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [15:0]                       rsp_out_sample,
   output logic [2:0]                               rsp_status,
   output logic                                     rsp_playing,
   output logic                                     rsp_rebuffering_now,
   output logic [15:0]                              rsp_pending_count,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pjb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [pjb_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pjb_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   pjb_pkg::cfg_type              cfg;
   pjb_pkg::result_type           result;
   logic                          accept;
   logic                          ram_we, ram_re;
   logic [pjb_pkg::PTR_W-1:0]     ram_waddr, ram_raddr;
   logic [pjb_pkg::SAMPLE_W-1:0]  ram_wdata, ram_rdata;
   logic [pjb_pkg::SAMPLE_W-1:0]  out_sample;

   assign accept = req_valid && !req_stall;

   pjb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pjb_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_type),
      .in_sample   (req_in_sample),
      .block_start (req_block_start),
      .block_len   (req_block_len),
      .cfg         (cfg),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .result      (result)
   );

   pjb_ram #(
      .WIDTH (pjb_pkg::SAMPLE_W),
      .DEPTH (pjb_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pjb_out u_out (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .result              (result),
      .ram_rdata           (ram_rdata),
      .in_stall            (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_sample      (out_sample),
      .rsp_status          (rsp_status),
      .rsp_playing         (rsp_playing),
      .rsp_rebuffering_now (rsp_rebuffering_now),
      .rsp_pending_count   (rsp_pending_count)
   );

   assign rsp_out_sample = out_sample;

endmodule
`default_nettype wire

FILE: hdl/pjb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pjb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/pjb_csr.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module pjb_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pjb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [pjb_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [pjb_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                     pready,
   output pjb_pkg::cfg_type                         cfg
);

   pjb_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       reg_index;
   logic             wr_strobe;

   assign reg_index = paddr[3:2];
   assign wr_strobe = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_index)
            pjb_pkg::CSR_QUEUE_LIMIT:     cfg_in.queue_limit     = pwdata[15:0];
            pjb_pkg::CSR_PREBUFFER_LEVEL: cfg_in.prebuffer_level = pwdata[15:0];
            pjb_pkg::CSR_REBUFFER_LEVEL:  cfg_in.rebuffer_level  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         pjb_pkg::CSR_QUEUE_LIMIT:     prdata = {16'd0, cfg_ff.queue_limit};
         pjb_pkg::CSR_PREBUFFER_LEVEL: prdata = {16'd0, cfg_ff.prebuffer_level};
         pjb_pkg::CSR_REBUFFER_LEVEL:  prdata = {16'd0, cfg_ff.rebuffer_level};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_limit     <= pjb_pkg::QUEUE_LIMIT_RESET;
         cfg_ff.prebuffer_level <= pjb_pkg::PREBUFFER_LEVEL_RESET;
         cfg_ff.rebuffer_level  <= pjb_pkg::REBUFFER_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: hdl/pjb_core.sv
// Queue control: block admission, pointers, pending count and playback state.
`default_nettype none
module pjb_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic                            req_type,
   input  wire logic [pjb_pkg::SAMPLE_W-1:0]    in_sample,
   input  wire logic                            block_start,
   input  wire logic [pjb_pkg::LEVEL_W-1:0]     block_len,
   input  pjb_pkg::cfg_type                     cfg,
   output logic                                 ram_we,
   output logic      [pjb_pkg::PTR_W-1:0]       ram_waddr,
   output logic      [pjb_pkg::SAMPLE_W-1:0]    ram_wdata,
   output logic                                 ram_re,
   output logic      [pjb_pkg::PTR_W-1:0]       ram_raddr,
   output pjb_pkg::result_type                  result
);

   localparam int PTR_W = pjb_pkg::PTR_W;
   localparam int CNT_W = pjb_pkg::CNT_W;
   localparam int SUM_W = pjb_pkg::SUM_W;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(pjb_pkg::RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(pjb_pkg::RING_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(pjb_pkg::RING_DEPTH);

   logic [PTR_W-1:0]            wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]            pend_ff, pend_in;
   logic                        started_ff, started_in;
   logic                        rebuf_ff, rebuf_in;
   logic                        blk_acc_ff, blk_acc_in;
   logic [pjb_pkg::LEVEL_W-1:0] blk_rem_ff, blk_rem_in;

   logic [SUM_W-1:0]   limit_ext, eff_limit, pend_ext, len_ext;
   logic               hold;
   logic               do_store;
   pjb_pkg::status_type status;

   assign limit_ext = SUM_W'(cfg.queue_limit);
   assign eff_limit = (limit_ext < DEPTH_SUM) ? limit_ext : DEPTH_SUM;
   assign pend_ext  = SUM_W'(pend_ff);
   assign len_ext   = SUM_W'(block_len);
   assign hold      = rebuf_ff && (pend_ext < SUM_W'(cfg.rebuffer_level));

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      pend_in    = pend_ff;
      started_in = started_ff;
      rebuf_in   = rebuf_ff;
      blk_acc_in = blk_acc_ff;
      blk_rem_in = blk_rem_ff;
      status     = pjb_pkg::ST_REJECTED;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      do_store   = 1'b0;
      if (accept) begin
         if (req_type == pjb_pkg::REQ_PUSH) begin
            if (block_start) begin
               if ((eff_limit == '0) || (block_len == '0)) begin
                  blk_acc_in = 1'b0;
                  blk_rem_in = '0;
                  status     = pjb_pkg::ST_REJECTED;
               end else if ((pend_ext + len_ext) > eff_limit) begin
                  blk_acc_in = 1'b0;
                  blk_rem_in = block_len - 16'd1;
                  status     = pjb_pkg::ST_DROPPED;
               end else begin
                  blk_acc_in = 1'b1;
                  blk_rem_in = block_len - 16'd1;
                  do_store   = 1'b1;
               end
            end else if (blk_rem_ff == '0) begin
               status = pjb_pkg::ST_REJECTED;
            end else if (!blk_acc_ff) begin
               blk_rem_in = blk_rem_ff - 16'd1;
               status     = pjb_pkg::ST_DROPPED;
            end else begin
               blk_rem_in = blk_rem_ff - 16'd1;
               do_store   = 1'b1;
            end
            if (do_store) begin
               // A word that finds the ring full is dropped rather than written.
               if (pend_ff == FULL_CNT) begin
                  status = pjb_pkg::ST_DROPPED;
               end else begin
                  ram_we  = 1'b1;
                  wp_in   = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
                  pend_in = pend_ff + 1'b1;
                  status  = pjb_pkg::ST_STORED;
               end
               if (blk_rem_in == '0) begin
                  if (!started_ff &&
                      (SUM_W'(pend_in) >= SUM_W'(cfg.prebuffer_level))) begin
                     started_in = 1'b1;
                  end
                  blk_acc_in = 1'b0;
               end
            end
         end else if (!started_ff) begin
            status = pjb_pkg::ST_NOT_STARTED;
         end else begin
            if (rebuf_ff && !hold) begin
               rebuf_in = 1'b0;
            end
            if (hold) begin
               status = pjb_pkg::ST_HOLD;
            end else if (pend_ff != '0) begin
               ram_re  = 1'b1;
               rp_in   = (rp_ff == LAST_PTR) ? '0 : rp_ff + 1'b1;
               pend_in = pend_ff - 1'b1;
               status  = pjb_pkg::ST_REAL;
            end else begin
               rebuf_in = 1'b1;
               status   = pjb_pkg::ST_UNDERRUN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         pend_ff    <= '0;
         started_ff <= 1'b0;
         rebuf_ff   <= 1'b0;
         blk_acc_ff <= 1'b0;
         blk_rem_ff <= '0;
      end else begin
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         pend_ff    <= pend_in;
         started_ff <= started_in;
         rebuf_ff   <= rebuf_in;
         blk_acc_ff <= blk_acc_in;
         blk_rem_ff <= blk_rem_in;
      end
   end

   assign ram_waddr = wp_ff;
   assign ram_wdata = in_sample;
   assign ram_raddr = rp_ff;

   assign result.status      = status;
   assign result.playing     = started_in;
   assign result.rebuffering = rebuf_in;
   assign result.pending     = pjb_pkg::LEVEL_W'(pend_in);
   assign result.is_real     = ram_re;

endmodule
`default_nettype wire

FILE: hdl/pjb_out.sv
// Result pipeline: ring read stage followed by the output register.
`default_nettype none
module pjb_out (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  pjb_pkg::result_type                result,
   input  wire logic [pjb_pkg::SAMPLE_W-1:0]  ram_rdata,
   output logic                               in_stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [pjb_pkg::SAMPLE_W-1:0]  rsp_out_sample,
   output logic      [2:0]                    rsp_status,
   output logic                               rsp_playing,
   output logic                               rsp_rebuffering_now,
   output logic      [pjb_pkg::LEVEL_W-1:0]   rsp_pending_count
);

   logic                        s1_valid_ff, s1_valid_in;
   pjb_pkg::result_type         s1_ff;
   logic                        out_valid_ff, out_valid_in;
   pjb_pkg::result_type         out_ff;
   logic [pjb_pkg::SAMPLE_W-1:0] out_sample_ff;
   logic                        advance;

   // The read stage moves on whenever the output register is free or being emptied.
   assign advance      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_stall     = s1_valid_ff && !advance;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= result;
      end
      if (advance) begin
         out_ff        <= s1_ff;
         out_sample_ff <= s1_ff.is_real ? ram_rdata : '0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_out_sample      = out_sample_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_playing         = out_ff.playing;
   assign rsp_rebuffering_now = out_ff.rebuffering;
   assign rsp_pending_count   = out_ff.pending;

endmodule
`default_nettype wire

FILE: hdl/pjb_checker.sv
// Port-level checks on the jitter buffer's result channel, bound to the top level.
`default_nettype none
module pjb_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_out_sample,
   input wire logic [2:0]         rsp_status,
   input wire logic               rsp_playing,
   input wire logic               rsp_rebuffering_now
);

   // A held result word must keep its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_sample) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // Only a real playback word carries a nonzero sample.
   a_silence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pjb_pkg::ST_REAL) |-> rsp_out_sample == 16'sd0)
      else $error("nonzero sample on a word that is not a real sample");

   // Rebuffering can only happen once playback has started.
   a_rebuf_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rebuffering_now |-> rsp_playing)
      else $error("rebuffering without playback started");

   // A pull before start leaves playback stopped; a hold keeps rebuffering and an underrun starts it.
   a_status_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status != pjb_pkg::ST_NOT_STARTED) || !rsp_playing) &&
                    ((rsp_status != pjb_pkg::ST_HOLD) || rsp_rebuffering_now) &&
                    ((rsp_status != pjb_pkg::ST_UNDERRUN) || rsp_rebuffering_now))
      else $error("status disagrees with playback state");

   // Reset empties the result channel.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pcm_jitter_buffer_with_rebuffer_top pjb_checker u_pjb_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_sample      (rsp_out_sample),
   .rsp_status          (rsp_status),
   .rsp_playing         (rsp_playing),
   .rsp_rebuffering_now (rsp_rebuffering_now)
);
`default_nettype wire
